>>> src/edc_pkg.sv
// ----------------------------------------------------------------------------
// edc_pkg
// Shared types and constants for the encoder direction check sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package edc_pkg;

  localparam int POS_WIDTH_DEF = 32;

  localparam int CPR_W = 16;
  localparam int SDL_W = 12;
  localparam int TOL_W = 10;
  localparam int ENC_W = 32;
  localparam int DRV_W = 13;
  localparam int STATUS_W = 16;
  localparam int VERDICT_W = 2;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  // in_tdata: seek_done, enc_position -> 33 bits, padded to 40
  localparam int IN_TDATA_W = 40;
  // out_tdata: status_word, verdict, drive_level, reset_ctrl, reset_pos,
  // restart_seek -> 34 bits, padded to 40
  localparam int OUT_TDATA_W = 40;

  localparam logic [CFG_ADDR_W-1:0] REG_COUNTS_PER_REV   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SEEK_DRIVE_LEVEL = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MATCH_TOLERANCE  = 2'd2;

  localparam logic [CPR_W-1:0] CPR_RST = 16'd4096;
  localparam logic [SDL_W-1:0] SDL_RST = 12'd491;
  localparam logic [TOL_W-1:0] TOL_RST = 10'd10;

  localparam logic [STATUS_W-1:0] STATUS_IDLE    = 16'h0000;
  localparam logic [STATUS_W-1:0] STATUS_RUNNING = 16'haaaa;
  localparam logic [STATUS_W-1:0] STATUS_FAILED  = 16'hbbbb;

  localparam logic [VERDICT_W-1:0] VERDICT_NONE = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_PASS = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_FAIL = 2'd2;

  typedef enum logic [3:0] {
    PH_BEGIN  = 4'b0001,
    PH_FIRST  = 4'b0010,
    PH_SECOND = 4'b0100,
    PH_RETURN = 4'b1000
  } edc_phase_t;

  typedef struct packed {
    logic [CPR_W-1:0] counts_per_rev;
    logic [SDL_W-1:0] seek_drive_level;
    logic [TOL_W-1:0] match_tolerance;
  } edc_cfg_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status_word;
    logic [VERDICT_W-1:0] verdict;
    logic [DRV_W-1:0]     drive_level;  // two's complement
    logic                 reset_ctrl;
    logic                 reset_pos;
    logic                 restart_seek;
  } edc_result_t;

endpackage

`default_nettype wire

>>> src/edc_cfg.sv
// ----------------------------------------------------------------------------
// edc_cfg
// Configuration register file: counts per revolution, seek drive level and
// revolution match tolerance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module edc_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [edc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [edc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output edc_pkg::edc_cfg_t                   cfg_o
);
  import edc_pkg::*;

  edc_cfg_t cfg_r;
  edc_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_COUNTS_PER_REV:   cfg_nxt.counts_per_rev   = cfg_wdata[CPR_W-1:0];
        REG_SEEK_DRIVE_LEVEL: cfg_nxt.seek_drive_level = cfg_wdata[SDL_W-1:0];
        REG_MATCH_TOLERANCE:  cfg_nxt.match_tolerance  = cfg_wdata[TOL_W-1:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.counts_per_rev   <= CPR_RST;
      cfg_r.seek_drive_level <= SDL_RST;
      cfg_r.match_tolerance  <= TOL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

`default_nettype wire

>>> src/edc_core.sv
// ----------------------------------------------------------------------------
// edc_core
// Phase sequencer state and the single-step logic that turns one request into
// one result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module edc_core #(
  parameter int POS_WIDTH = edc_pkg::POS_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             step_en,
  input  wire logic                             func,
  input  wire logic                             seek_done,
  input  wire logic signed [edc_pkg::ENC_W-1:0] enc_position,
  input  edc_pkg::edc_cfg_t                     cfg,
  output edc_pkg::edc_result_t                  result
);
  import edc_pkg::*;

  localparam int ERR_W = POS_WIDTH + 2;

  edc_phase_t                   phase_r, phase_nxt;
  logic signed [POS_WIDTH-1:0]  start_pos_r, start_pos_nxt;
  logic signed [POS_WIDTH-1:0]  first_pos_r, first_pos_nxt;
  logic [STATUS_W-1:0]          status_r, status_nxt;

  logic signed [POS_WIDTH-1:0]  pos;
  logic signed [ERR_W-1:0]      err;
  logic signed [ERR_W-1:0]      tol;
  logic                         rev_ok;
  logic signed [DRV_W-1:0]      drv_fwd;

  // sign-extend or wrap to the position width
  assign pos = POS_WIDTH'(enc_position);

  assign err = ERR_W'(pos)
             - ERR_W'(signed'({1'b0, cfg.counts_per_rev}))
             - ERR_W'(first_pos_r);
  assign tol = ERR_W'(signed'({1'b0, cfg.match_tolerance}));
  assign rev_ok = (err < tol) && (err > -tol);

  assign drv_fwd = DRV_W'(signed'({1'b0, cfg.seek_drive_level}));

  always_comb begin
    phase_nxt     = phase_r;
    start_pos_nxt = start_pos_r;
    first_pos_nxt = first_pos_r;
    status_nxt    = status_r;
    result        = '0;
    result.status_word = status_r;

    if (!func) begin
      phase_nxt          = PH_BEGIN;
      start_pos_nxt      = '0;
      first_pos_nxt      = '0;
      status_nxt         = STATUS_IDLE;
      result.status_word = STATUS_IDLE;
    end else begin
      case (phase_r)
        PH_BEGIN: begin
          start_pos_nxt       = pos;
          status_nxt          = STATUS_RUNNING;
          result.status_word  = STATUS_RUNNING;
          phase_nxt           = PH_FIRST;
          result.reset_ctrl   = 1'b1;
          result.reset_pos    = 1'b1;
          result.restart_seek = 1'b1;
        end
        PH_FIRST: begin
          if (!seek_done) begin
            result.drive_level = drv_fwd;
          end else begin
            first_pos_nxt       = pos;
            phase_nxt           = PH_SECOND;
            result.reset_pos    = 1'b1;
            result.restart_seek = 1'b1;
          end
        end
        PH_SECOND: begin
          if (!seek_done) begin
            result.drive_level = drv_fwd;
          end else if (rev_ok) begin
            phase_nxt = PH_RETURN;
          end else begin
            phase_nxt          = PH_BEGIN;
            status_nxt         = STATUS_FAILED;
            result.status_word = STATUS_FAILED;
            result.verdict     = VERDICT_FAIL;
          end
        end
        PH_RETURN: begin
          if (pos > start_pos_r) begin
            result.drive_level = -drv_fwd;
          end else begin
            phase_nxt          = PH_BEGIN;
            status_nxt         = STATUS_IDLE;
            result.status_word = STATUS_IDLE;
            result.verdict     = VERDICT_PASS;
          end
        end
        default: begin
          phase_nxt = PH_BEGIN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_BEGIN;
      start_pos_r <= '0;
      first_pos_r <= '0;
      status_r    <= STATUS_IDLE;
    end else if (step_en) begin
      phase_r     <= phase_nxt;
      start_pos_r <= start_pos_nxt;
      first_pos_r <= first_pos_nxt;
      status_r    <= status_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/encoder_direction_check_fsm.sv
// ----------------------------------------------------------------------------
// encoder_direction_check_fsm
// Encoder direction diagnostic: begin, first index, second index with
// revolution check, return to start, then pass or fail verdict.
// ----------------------------------------------------------------------------
// Flow: a request loads the input register when it is accepted; its result
//   loads the result register when the result stage next advances.
// Throughput: one request per cycle while out_tready does not stall the result;
//   the step logic sits between the registers, phase state updates per request.
// Reset: synchronous, active low; clears phase, captured positions, status
//   and both valid flags, and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module encoder_direction_check_fsm #(
  parameter int POS_WIDTH = edc_pkg::POS_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // [0] seek_done, [32:1] enc_position, [39:33] zero
  input  wire logic [edc_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] func
  input  wire logic                            in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // [15:0] status_word, [17:16] verdict, [30:18] drive_level,
  // [31] reset_ctrl, [32] reset_pos, [33] restart_seek, [39:34] zero
  output logic [edc_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input  wire logic                            cfg_we,
  input  wire logic [edc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [edc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import edc_pkg::*;

  edc_cfg_t             cfg;
  edc_result_t          result;

  logic                 in_vld_r;
  logic                 func_r;
  logic                 seek_done_r;
  logic signed [ENC_W-1:0] enc_pos_r;
  logic                 out_vld_r;
  edc_result_t          out_res_r;
  logic                 advance;
  logic                 step_en;

  assign advance   = !out_vld_r || out_tready;
  assign step_en   = in_vld_r && advance;
  assign in_tready = !in_vld_r || advance;

  edc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  edc_core #(
    .POS_WIDTH (POS_WIDTH)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (step_en),
    .func         (func_r),
    .seek_done    (seek_done_r),
    .enc_position (enc_pos_r),
    .cfg          (cfg),
    .result       (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      func_r      <= in_tuser;
      seek_done_r <= in_tdata[0];
      enc_pos_r   <= in_tdata[ENC_W:1];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0,
                       out_res_r.restart_seek,
                       out_res_r.reset_pos,
                       out_res_r.reset_ctrl,
                       out_res_r.drive_level,
                       out_res_r.verdict,
                       out_res_r.status_word};

endmodule

`default_nettype wire

>>> src/edc_checker.sv
// ----------------------------------------------------------------------------
// edc_checker
// Port-level checks on the result stream of the direction check sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module edc_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [edc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import edc_pkg::*;

  logic [STATUS_W-1:0]  status_w;
  logic [VERDICT_W-1:0] verdict_w;
  logic [DRV_W-1:0]     drive_w;

  assign status_w  = out_tdata[15:0];
  assign verdict_w = out_tdata[17:16];
  assign drive_w   = out_tdata[30:18];

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && verdict_w == VERDICT_PASS |->
      status_w == STATUS_IDLE && drive_w == '0 && out_tdata[33:31] == 3'b000)
    else $error("pass result with status or drive set");

  a_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && verdict_w == VERDICT_FAIL |->
      status_w == STATUS_FAILED && drive_w == '0)
    else $error("fail result without failed status");

  // controller reset only happens at the start of a run
  a_begin: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[31] |->
      status_w == STATUS_RUNNING && out_tdata[32] && out_tdata[33]
      && verdict_w == VERDICT_NONE)
    else $error("controller reset outside begin step");

endmodule

bind encoder_direction_check_fsm edc_checker u_edc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

>>> tb/encoder_direction_check_fsm_tb.sv
// ----------------------------------------------------------------------------
// encoder_direction_check_fsm_tb
// Self-checking bench for the encoder direction diagnostic sequencer. A
// scoreboard class tracks phase, captured positions and status, predicts one
// result per accepted request and checks results in order. Stimulus is a short
// directed run, then mostly well-formed diagnostic runs with random content,
// mixed with cut-short runs and noise, over several register settings.
// Both stream sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module encoder_direction_check_fsm_tb;
  import edc_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 4;
  localparam int ITEMS_PER_SETTING = 300;

  class sequencer_scoreboard;
    logic [CPR_W-1:0]           counts_per_rev;
    logic [SDL_W-1:0]           seek_drive_level;
    logic [TOL_W-1:0]           match_tolerance;
    edc_phase_t                 phase;
    logic signed [ENC_W-1:0]    start_pos;
    logic signed [ENC_W-1:0]    first_index_pos;
    logic [STATUS_W-1:0]        status_reg;
    edc_result_t                pending_results[$];
    int                         failures;

    function new();
      counts_per_rev   = CPR_RST;
      seek_drive_level = SDL_RST;
      match_tolerance  = TOL_RST;
      phase            = PH_BEGIN;
      start_pos        = '0;
      first_index_pos  = '0;
      status_reg       = STATUS_IDLE;
      failures         = 0;
    endfunction

    function void write_register(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
      case (addr)
        REG_COUNTS_PER_REV:   counts_per_rev   = data[CPR_W-1:0];
        REG_SEEK_DRIVE_LEVEL: seek_drive_level = data[SDL_W-1:0];
        REG_MATCH_TOLERANCE:  match_tolerance  = data[TOL_W-1:0];
        default: ;
      endcase
    endfunction

    // One sequencer step per accepted request.
    function void note_request(bit func, bit seek_done, logic signed [ENC_W-1:0] pos);
      edc_result_t res;
      longint      rev_err;
      longint      tol;
      res = '0;
      res.status_word = status_reg;
      tol = longint'(match_tolerance);
      if (!func) begin
        phase           = PH_BEGIN;
        start_pos       = '0;
        first_index_pos = '0;
        status_reg      = STATUS_IDLE;
        res.status_word = STATUS_IDLE;
      end else begin
        case (phase)
          PH_BEGIN: begin
            start_pos       = pos;
            status_reg      = STATUS_RUNNING;
            res.status_word = STATUS_RUNNING;
            phase           = PH_FIRST;
            res.reset_ctrl   = 1'b1;
            res.reset_pos    = 1'b1;
            res.restart_seek = 1'b1;
          end
          PH_FIRST: begin
            if (!seek_done) begin
              res.drive_level = {1'b0, seek_drive_level};
            end else begin
              first_index_pos  = pos;
              phase            = PH_SECOND;
              res.reset_pos    = 1'b1;
              res.restart_seek = 1'b1;
            end
          end
          PH_SECOND: begin
            if (!seek_done) begin
              res.drive_level = {1'b0, seek_drive_level};
            end else begin
              rev_err = longint'(pos) - longint'(counts_per_rev) - longint'(first_index_pos);
              if (rev_err < tol && rev_err > -tol) begin
                phase = PH_RETURN;
              end else begin
                phase           = PH_BEGIN;
                status_reg      = STATUS_FAILED;
                res.status_word = STATUS_FAILED;
                res.verdict     = VERDICT_FAIL;
              end
            end
          end
          default: begin
            if (pos > start_pos) begin
              res.drive_level = '0 - {1'b0, seek_drive_level};
            end else begin
              phase           = PH_BEGIN;
              status_reg      = STATUS_IDLE;
              res.status_word = STATUS_IDLE;
              res.verdict     = VERDICT_PASS;
            end
          end
        endcase
      end
      pending_results.push_back(res);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] d);
      edc_result_t want;
      edc_result_t got;
      got.status_word  = d[15:0];
      got.verdict      = d[17:16];
      got.drive_level  = d[30:18];
      got.reset_ctrl   = d[31];
      got.reset_pos    = d[32];
      got.restart_seek = d[33];
      if (pending_results.size() == 0) begin
        failures++;
        $display("%0t: result with nothing pending: %h", $time, d);
        return;
      end
      want = pending_results.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= 50)
          $display("%0t: mismatch status %h/%h verdict %0d/%0d drive %0d/%0d rc,rp,rs %b%b%b/%b%b%b",
                   $time, want.status_word, got.status_word, want.verdict, got.verdict,
                   $signed(want.drive_level), $signed(got.drive_level),
                   want.reset_ctrl, want.reset_pos, want.restart_seek,
                   got.reset_ctrl, got.reset_pos, got.restart_seek);
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata;   // [0] seek_done, [32:1] enc_position, [39:33] zero
  logic                    in_tuser;   // [0] func
  logic                    out_tvalid;
  logic                    out_tready;
  logic [OUT_TDATA_W-1:0]  out_tdata;  // [15:0] status, [17:16] verdict, [30:18] drive,
                                       // [31] reset_ctrl, [32] reset_pos, [33] restart_seek
  logic                    cfg_we;
  logic [CFG_ADDR_W-1:0]   cfg_addr;
  logic [CFG_DATA_W-1:0]   cfg_wdata;

  sequencer_scoreboard     board;
  int                      cycle_count;
  int                      sent_count;
  bit                      steady;
  bit                      need_clear;
  logic [CPR_W-1:0]        cur_cpr;
  logic [TOL_W-1:0]        cur_tol;

  encoder_direction_check_fsm DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      board.note_request(in_tuser, in_tdata[0], in_tdata[32:1]);
    if (rst_n && out_tvalid && out_tready)
      board.check_result(out_tdata);
  end

  // mostly short gaps, a few long ones; none during steady stretches
  function automatic int idle_gap();
    int r;
    if (steady)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  initial begin : result_sink
    int hold;
    out_tready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      hold = idle_gap();
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  task automatic send_request(bit func, bit done, logic [ENC_W-1:0] pos);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {7'b0, pos, done};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_count++;
  endtask

  // wait until every pending result has come back, plus pipeline latency
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    board.write_register(addr, data);
  endtask

  task automatic load_settings(logic [CPR_W-1:0] cpr, logic [SDL_W-1:0] sdl,
                               logic [TOL_W-1:0] tol);
    write_reg(REG_COUNTS_PER_REV, CFG_DATA_W'(cpr));
    write_reg(REG_SEEK_DRIVE_LEVEL, CFG_DATA_W'(sdl));
    write_reg(REG_MATCH_TOLERANCE, CFG_DATA_W'(tol));
    cfg_we  <= 1'b0;
    cur_cpr = cpr;
    cur_tol = tol;
  endtask

  function automatic logic [ENC_W-1:0] pick_position();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4, 5, 6: return $urandom;
      default: return $urandom_range(0, 20000) - 10000;
    endcase
  endfunction

  task automatic clear_request();
    send_request(1'b0, 1'($urandom_range(0, 1)), $urandom);
  endtask

  // begin, seek first index, seek second index, return; cut short when broken
  task automatic diagnostic_run(bit broken);
    int              cut;
    int              tol_i;
    int              err;
    longint          rev_err;
    logic [ENC_W-1:0] start;
    logic [ENC_W-1:0] p1;
    logic [ENC_W-1:0] p2;
    cut   = broken ? $urandom_range(0, 3) : 99;
    tol_i = int'(cur_tol);
    if (need_clear || $urandom_range(0, 3) == 0)
      clear_request();
    need_clear = 1'b0;
    start = pick_position();
    send_request(1'b1, 1'($urandom_range(0, 1)), start);
    if (cut == 0) begin
      clear_request();
      return;
    end
    repeat ($urandom_range(0, 3)) send_request(1'b1, 1'b0, start + $urandom_range(0, 5000));
    p1 = pick_position();
    send_request(1'b1, 1'b1, p1);
    if (cut == 1) begin
      clear_request();
      return;
    end
    repeat ($urandom_range(0, 3)) send_request(1'b1, 1'b0, $urandom);
    case ($urandom_range(0, 7))
      0: err = 0;
      1: err = tol_i - 1;
      2: err = 1 - tol_i;
      3: err = tol_i;
      4: err = -tol_i;
      default: err = (tol_i > 1) ? int'($urandom_range(0, 2 * tol_i - 2)) - (tol_i - 1) : 0;
    endcase
    p2 = ($urandom_range(0, 11) == 0) ? $urandom : p1 + {16'b0, cur_cpr} + err;
    send_request(1'b1, 1'b1, p2);
    if (cut == 2) begin
      clear_request();
      return;
    end
    rev_err = longint'($signed(p2)) - longint'(cur_cpr) - longint'($signed(p1));
    if (rev_err < tol_i && rev_err > -tol_i) begin
      repeat ($urandom_range(0, 3))
        send_request(1'b1, 1'($urandom_range(0, 1)), start + $urandom_range(1, 3000));
      if (cut == 3) begin
        clear_request();
        return;
      end
      send_request(1'b1, 1'($urandom_range(0, 1)), start - $urandom_range(0, 3000));
      // a wrapped return position may leave the sequencer mid-run
      if (start > 32'h7fff_f000 && start < 32'h8000_1000)
        need_clear = 1'b1;
    end
  endtask

  task automatic random_phase(int count);
    int target;
    int r;
    target = sent_count + count;
    while (sent_count < target) begin
      steady = ($urandom_range(0, 9) == 0);
      r = $urandom_range(0, 9);
      if (r < 7) begin
        diagnostic_run(1'b0);
      end else if (r < 8) begin
        diagnostic_run(1'b1);
      end else begin
        repeat ($urandom_range(1, 4))
          send_request($urandom_range(0, 7) != 0, 1'($urandom_range(0, 1)), pick_position());
        need_clear = 1'b1;
      end
    end
    steady = 1'b0;
    drain();
  endtask

  initial begin : main
    board       = new();
    cycle_count = 0;
    sent_count  = 0;
    steady      = 1'b0;
    need_clear  = 1'b0;
    cur_cpr     = CPR_RST;
    cur_tol     = TOL_RST;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tuser    = 1'b0;
    in_tdata    = '0;
    cfg_we      = 1'b0;
    cfg_addr    = '0;
    cfg_wdata   = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed run at the register defaults
    send_request(1'b0, 1'b1, 32'hffff_ffff);          // clear when already idle
    send_request(1'b1, 1'b0, 32'd100);                // begin, start at 100
    send_request(1'b1, 1'b0, 32'h7fff_ffff);          // seeking forward
    send_request(1'b1, 1'b1, 32'h8000_0000);          // first index at most negative
    send_request(1'b1, 1'b0, 32'd0);
    send_request(1'b1, 1'b1, 32'h8000_1009);          // error just inside tolerance
    send_request(1'b1, 1'b0, 32'd101);                // return, still past start
    send_request(1'b1, 1'b1, 32'd100);                // back at start: pass
    send_request(1'b1, 1'b1, -32'sd5);
    send_request(1'b1, 1'b1, 32'h7fff_ffff);          // first index at most positive
    send_request(1'b1, 1'b1, 32'h8000_0000);          // huge negative error: fail
    send_request(1'b1, 1'b0, 32'd0);
    send_request(1'b1, 1'b1, 32'd0);
    send_request(1'b1, 1'b1, 32'd4106);               // error equals tolerance: fail
    send_request(1'b1, 1'b0, 32'd0);
    send_request(1'b1, 1'b1, 32'd0);
    send_request(1'b1, 1'b1, 32'd4086);               // error equals minus tolerance
    send_request(1'b1, 1'b0, 32'd0);
    send_request(1'b1, 1'b1, 32'd0);
    send_request(1'b1, 1'b1, 32'd4087);
    send_request(1'b1, 1'b0, 32'hffff_ffff);          // below start: pass
    send_request(1'b1, 1'b0, 32'd7);
    send_request(1'b0, 1'b0, 32'd7);                  // clear mid-run
    drain();

    load_settings(16'd4096, 12'd491, 10'd10);
    random_phase(ITEMS_PER_SETTING);
    load_settings(16'd1, 12'd0, 10'd1);
    random_phase(ITEMS_PER_SETTING);
    load_settings(16'd65535, 12'd4095, 10'd1023);
    random_phase(ITEMS_PER_SETTING);
    load_settings(16'd4096, 12'd491, 10'd0);          // zero tolerance: every check fails
    random_phase(ITEMS_PER_SETTING);
    load_settings(CPR_W'($urandom_range(1, 65535)), SDL_W'($urandom_range(0, 4095)),
                  TOL_W'($urandom_range(1, 1023)));
    random_phase(ITEMS_PER_SETTING);
    load_settings(CPR_W'($urandom_range(1, 300)), SDL_W'($urandom_range(0, 4095)),
                  TOL_W'($urandom_range(1, 16)));
    random_phase(ITEMS_PER_SETTING);

    if (board.failures == 0 && board.pending_results.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> encoder_direction_check_fsm.f
src/edc_pkg.sv
src/edc_cfg.sv
src/edc_core.sv
src/encoder_direction_check_fsm.sv
src/edc_checker.sv
tb/encoder_direction_check_fsm_tb.sv
